// File: hdl/heap_sort_engine_macros.svh
// Assertion macros for the heap sort engine checker.
// No dependencies; included by files that hold concurrent assertions.
`ifndef HEAP_SORT_ENGINE_MACROS_SVH
`define HEAP_SORT_ENGINE_MACROS_SVH

// Check cons in the cycle where ante holds.
`define HSE_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check cons in the cycle after ante holds.
`define HSE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hdl/hse_pkg.sv
// Shared types and constants for the heap sort engine.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps

package hse_pkg;

    localparam int DATA_WIDTH = 32;
    localparam int DEPTH_DEF  = 16;

    typedef struct packed {
        logic signed [DATA_WIDTH-1:0] element;
        logic                         last_in;
    } t_in_word;

    typedef struct packed {
        logic signed [DATA_WIDTH-1:0] sorted_value;
        logic                         last_out;
        logic                         overflowed;
    } t_out_word;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_PREP,
        ST_BUILD_FETCH,
        ST_BUILD_LOAD,
        ST_SIFT_RD,
        ST_SIFT_CMP,
        ST_EXTR_FETCH,
        ST_EXTR_LOAD,
        ST_EMIT
    } t_state;

    typedef enum logic [1:0] {
        RD_CHILD,
        RD_BUILD,
        RD_EXTR,
        RD_EMIT
    } t_rd_sel;

    typedef struct packed {
        logic    accept;
        logic    init_build;
        logic    build_fetch;
        logic    build_load;
        logic    next_build;
        logic    init_extract;
        logic    extr_fetch;
        logic    extr_load;
        logic    sift_step;
        logic    init_emit;
        logic    emit;
        logic    clear;
        t_rd_sel rd_sel;
    } t_dp_cmd;

    typedef struct packed {
        logic sift_more;
        logic i_zero;
        logic i_lt2;
        logic emit_last;
    } t_dp_stat;

endpackage

// File: hdl/hse_ctrl.sv
// Sequencer for the heap sort engine: load, heap build, extract and emit phases.
// Depends on hse_pkg; drives hse_datapath through command and status structs.
`timescale 1ns / 1ps

module hse_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic               i_last_in,
    input  hse_pkg::t_dp_stat  i_stat,
    output hse_pkg::t_dp_cmd   o_cmd,
    output logic               o_busy
);

    hse_pkg::t_state r_state, n_state;
    logic            r_phase, n_phase;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= hse_pkg::ST_IDLE;
            r_phase <= 1'b0;
        end else begin
            r_state <= n_state;
            r_phase <= n_phase;
        end
    end

    always_comb begin
        n_state      = r_state;
        n_phase      = r_phase;
        o_cmd        = '0;
        o_cmd.rd_sel = hse_pkg::RD_CHILD;
        o_busy       = 1'b1;
        case (r_state)
            hse_pkg::ST_IDLE: begin
                o_busy  = 1'b0;
                n_phase = 1'b0;
                if (i_start) begin
                    o_cmd.accept = 1'b1;
                    if (i_last_in) begin
                        n_state = hse_pkg::ST_PREP;
                    end
                end
            end
            hse_pkg::ST_PREP: begin
                o_cmd.init_build = 1'b1;
                n_state          = hse_pkg::ST_BUILD_FETCH;
            end
            hse_pkg::ST_BUILD_FETCH: begin
                o_cmd.build_fetch = 1'b1;
                o_cmd.rd_sel      = hse_pkg::RD_BUILD;
                n_state           = hse_pkg::ST_BUILD_LOAD;
            end
            hse_pkg::ST_BUILD_LOAD: begin
                o_cmd.build_load = 1'b1;
                n_state          = hse_pkg::ST_SIFT_CMP;
            end
            hse_pkg::ST_SIFT_RD: begin
                n_state = hse_pkg::ST_SIFT_CMP;
            end
            hse_pkg::ST_SIFT_CMP: begin
                o_cmd.sift_step = 1'b1;
                if (i_stat.sift_more) begin
                    n_state = hse_pkg::ST_SIFT_RD;
                end else if (r_phase) begin
                    n_state = hse_pkg::ST_EXTR_FETCH;
                end else if (i_stat.i_zero) begin
                    o_cmd.init_extract = 1'b1;
                    n_phase            = 1'b1;
                    n_state            = hse_pkg::ST_EXTR_FETCH;
                end else begin
                    o_cmd.next_build = 1'b1;
                    n_state          = hse_pkg::ST_BUILD_FETCH;
                end
            end
            hse_pkg::ST_EXTR_FETCH: begin
                if (i_stat.i_lt2) begin
                    o_cmd.init_emit = 1'b1;
                    n_state         = hse_pkg::ST_EMIT;
                end else begin
                    o_cmd.extr_fetch = 1'b1;
                    o_cmd.rd_sel     = hse_pkg::RD_EXTR;
                    n_state          = hse_pkg::ST_EXTR_LOAD;
                end
            end
            hse_pkg::ST_EXTR_LOAD: begin
                o_cmd.extr_load = 1'b1;
                n_state         = hse_pkg::ST_SIFT_CMP;
            end
            hse_pkg::ST_EMIT: begin
                o_cmd.emit   = 1'b1;
                o_cmd.rd_sel = hse_pkg::RD_EMIT;
                if (i_stat.emit_last) begin
                    o_cmd.clear = 1'b1;
                    n_phase     = 1'b0;
                    n_state     = hse_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = hse_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

// File: hdl/hse_datapath.sv
// Datapath of the heap sort engine: value store, counters and sift compare unit.
// Depends on hse_pkg; commanded by hse_ctrl.
`timescale 1ns / 1ps

module hse_datapath #(
    parameter int DEPTH = hse_pkg::DEPTH_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  hse_pkg::t_dp_cmd   i_cmd,
    input  hse_pkg::t_in_word  i_item,
    output hse_pkg::t_dp_stat  o_stat,
    output logic               o_strobe,
    output hse_pkg::t_out_word o_result
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int XW = AW + 2;
    localparam int DW = hse_pkg::DATA_WIDTH;
    localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);

    logic signed [DW-1:0] r_mem [DEPTH];
    logic signed [DW-1:0] r_rd_a, r_rd_b;

    logic [CW-1:0]        r_cnt, n_cnt;
    logic                 r_ovf, n_ovf;
    logic [CW-1:0]        r_i, n_i;
    logic [CW-1:0]        r_len, n_len;
    logic [AW-1:0]        r_node, n_node;
    logic signed [DW-1:0] r_val, n_val;
    logic                 r_emit_v, n_emit_v;
    logic                 r_emit_last, n_emit_last;
    logic                 r_emit_ovf, n_emit_ovf;

    logic                 we;
    logic [AW-1:0]        waddr;
    logic signed [DW-1:0] wdata;
    logic [AW-1:0]        addr_a, addr_b;

    logic [XW-1:0]        node_x, child_l, child_r, len_x;
    logic [CW-1:0]        i_dec;
    logic                 l_ok, r_ok, big_l, big_r;
    logic signed [DW-1:0] big_lv, sift_val;
    logic [AW-1:0]        sift_node;

    assign node_x  = XW'(r_node);
    assign child_l = (node_x << 1) + XW'(1);
    assign child_r = (node_x << 1) + XW'(2);
    assign len_x   = XW'(r_len);
    assign i_dec   = r_i - 1'b1;

    assign l_ok      = child_l < len_x;
    assign r_ok      = child_r < len_x;
    assign big_l     = l_ok && (r_rd_a > r_val);
    assign big_lv    = big_l ? r_rd_a : r_val;
    assign big_r     = r_ok && (r_rd_b > big_lv);
    assign sift_val  = big_r ? r_rd_b : big_lv;
    assign sift_node = big_r ? child_r[AW-1:0] : child_l[AW-1:0];

    always_comb begin
        addr_a = child_l[AW-1:0];
        addr_b = child_r[AW-1:0];
        case (i_cmd.rd_sel)
            hse_pkg::RD_CHILD: begin
                addr_a = child_l[AW-1:0];
                addr_b = child_r[AW-1:0];
            end
            hse_pkg::RD_BUILD: begin
                addr_a = r_i[AW-1:0];
            end
            hse_pkg::RD_EXTR: begin
                addr_a = i_dec[AW-1:0];
                addr_b = '0;
            end
            hse_pkg::RD_EMIT: begin
                addr_a = r_i[AW-1:0];
            end
            default: begin
                addr_a = child_l[AW-1:0];
            end
        endcase
    end

    always_comb begin
        n_cnt       = r_cnt;
        n_ovf       = r_ovf;
        n_i         = r_i;
        n_len       = r_len;
        n_node      = r_node;
        n_val       = r_val;
        n_emit_v    = 1'b0;
        n_emit_last = r_emit_last;
        n_emit_ovf  = r_emit_ovf;
        we          = 1'b0;
        waddr       = r_node;
        wdata       = sift_val;
        if (i_cmd.accept) begin
            if (r_cnt < DEPTH_C) begin
                we    = 1'b1;
                waddr = r_cnt[AW-1:0];
                wdata = i_item.element;
                n_cnt = r_cnt + 1'b1;
            end else begin
                n_ovf = 1'b1;
            end
        end
        if (i_cmd.init_build) begin
            n_i   = r_cnt >> 1;
            n_len = r_cnt;
        end
        if (i_cmd.build_fetch) begin
            n_node = r_i[AW-1:0];
        end
        if (i_cmd.build_load) begin
            n_val = r_rd_a;
        end
        if (i_cmd.next_build) begin
            n_i = i_dec;
        end
        if (i_cmd.init_extract) begin
            n_i = r_cnt;
        end
        if (i_cmd.extr_fetch) begin
            n_node = '0;
            n_len  = i_dec;
        end
        if (i_cmd.extr_load) begin
            n_val = r_rd_a;
            we    = 1'b1;
            waddr = i_dec[AW-1:0];
            wdata = r_rd_b;
            n_i   = i_dec;
        end
        if (i_cmd.sift_step) begin
            we    = 1'b1;
            waddr = r_node;
            wdata = sift_val;
            if (big_l || big_r) begin
                n_node = sift_node;
            end
        end
        if (i_cmd.init_emit) begin
            n_i = '0;
        end
        if (i_cmd.emit) begin
            n_emit_v    = 1'b1;
            n_emit_last = o_stat.emit_last;
            n_emit_ovf  = r_ovf;
            n_i         = r_i + 1'b1;
        end
        if (i_cmd.clear) begin
            n_cnt = '0;
            n_ovf = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (we) begin
            r_mem[waddr] <= wdata;
        end
        r_rd_a <= r_mem[addr_a];
        r_rd_b <= r_mem[addr_b];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt    <= '0;
            r_ovf    <= 1'b0;
            r_emit_v <= 1'b0;
        end else begin
            r_cnt    <= n_cnt;
            r_ovf    <= n_ovf;
            r_emit_v <= n_emit_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_i         <= n_i;
        r_len       <= n_len;
        r_node      <= n_node;
        r_val       <= n_val;
        r_emit_last <= n_emit_last;
        r_emit_ovf  <= n_emit_ovf;
    end

    always_comb begin
        o_stat.sift_more = big_l || big_r;
        o_stat.i_zero    = (r_i == '0);
        o_stat.i_lt2     = (r_i < CW'(2));
        o_stat.emit_last = (r_i == (r_cnt - 1'b1));
    end

    assign o_strobe = r_emit_v;

    always_comb begin
        o_result.sorted_value = r_rd_a;
        o_result.last_out     = r_emit_last;
        o_result.overflowed   = r_emit_ovf;
    end

endmodule

// File: hdl/heap_sort_engine.sv
// Top level of the heap sort engine: controller plus datapath.
// Depends on hse_pkg, hse_ctrl and hse_datapath.
//
// Usage: drive i_item and raise start; a word is taken at a clock edge where start
// is high and busy is low. Words without last_in are stored and busy stays low.
// The word with last_in closes the set; busy then rises while the set is
// heap-sorted in a single-port-write store with two registered read ports.
// Each sift runs through fetch, load and compare states, plus a child read and a
// compare with write back per level moved; all sifts share the one compare unit.
// Results come out in ascending order, one per cycle on consecutive cycles, each
// marked by o_strobe for exactly one cycle; the receiver cannot stall, so it must
// take every word as it appears. The largest value carries last_out, and every
// result of a set carries overflowed if words were dropped for lack of room.
// busy falls in the cycle that shows the last result, and the next set may begin
// there. Reset clears the fill count, the overflow flag and the sequencer; the
// store itself is not cleared.
`timescale 1ns / 1ps

module heap_sort_engine #(
    parameter int DEPTH = hse_pkg::DEPTH_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    input  hse_pkg::t_in_word  i_item,
    output logic               busy,
    output logic               o_strobe,
    output hse_pkg::t_out_word o_result
);

    hse_pkg::t_dp_cmd  cmd;
    hse_pkg::t_dp_stat stat;

    hse_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (start),
        .i_last_in (i_item.last_in),
        .i_stat    (stat),
        .o_cmd     (cmd),
        .o_busy    (busy)
    );

    hse_datapath #(
        .DEPTH (DEPTH)
    ) u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (cmd),
        .i_item   (i_item),
        .o_stat   (stat),
        .o_strobe (o_strobe),
        .o_result (o_result)
    );

endmodule

// File: hdl/hse_checker.sv
// Port-level checks for the heap sort engine, bound to the top level.
// Depends on hse_pkg and heap_sort_engine_macros.svh.
`timescale 1ns / 1ps
`include "heap_sort_engine_macros.svh"

module hse_port_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               start,
    input hse_pkg::t_in_word  i_item,
    input logic               busy,
    input logic               o_strobe,
    input hse_pkg::t_out_word o_result
);

    `HSE_ASSERT_NEXT(a_last_starts_sort, i_clk, i_rst_n,
        start && !busy && i_item.last_in, busy,
        "last word did not start a sort")
    `HSE_ASSERT_NEXT(a_plain_word_fast, i_clk, i_rst_n,
        start && !busy && !i_item.last_in, !busy,
        "non-last word left the block busy")
    `HSE_ASSERT_NEXT(a_results_packed, i_clk, i_rst_n,
        o_strobe && !o_result.last_out,
        o_strobe && (o_result.overflowed == $past(o_result.overflowed)),
        "result stream broke or overflow flag changed")
    `HSE_ASSERT_NOW(a_done_with_last, i_clk, i_rst_n,
        $fell(busy) && $past(i_rst_n), o_strobe && o_result.last_out,
        "busy fell without the last result")

endmodule

bind heap_sort_engine hse_port_checker u_hse_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .start    (start),
    .i_item   (i_item),
    .busy     (busy),
    .o_strobe (o_strobe),
    .o_result (o_result)
);

// File: dv/hse_checker.sv
// Checker for the heap sort engine: watches the word and result channels,
// predicts each sorted set and compares every result word. Depends on hse_pkg.
`timescale 1ns / 1ps

module hse_checker (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic               i_busy,
    input  hse_pkg::t_in_word  i_item,
    input  logic               i_strobe,
    input  hse_pkg::t_out_word i_result,
    output int unsigned        o_fail_count,
    output int unsigned        o_pending,
    output int unsigned        o_sets,
    output int unsigned        o_overflow_sets,
    output int unsigned        o_results
);
    import hse_pkg::*;

    localparam int STORE_DEPTH  = DEPTH_DEF;
    localparam int REPORT_LIMIT = 10;

    int          ordered_set[$];
    bit          dropped_any;
    t_out_word   sorted_due[$];
    t_out_word   want;
    int unsigned fail_count;
    int unsigned sets_closed;
    int unsigned overflow_sets;
    int unsigned results_checked;

    task automatic take_element(input t_in_word w);
        int        pos;
        t_out_word due;
        if (ordered_set.size() < STORE_DEPTH) begin
            pos = 0;
            while (pos < ordered_set.size() && ordered_set[pos] <= int'(w.element))
                pos++;
            ordered_set.insert(pos, int'(w.element));
        end else begin
            dropped_any = 1'b1;
        end
        if (w.last_in) begin
            for (int k = 0; k < ordered_set.size(); k++) begin
                due.sorted_value = ordered_set[k];
                due.last_out     = (k == ordered_set.size() - 1);
                due.overflowed   = dropped_any;
                sorted_due.push_back(due);
            end
            sets_closed++;
            if (dropped_any)
                overflow_sets++;
            ordered_set.delete();
            dropped_any = 1'b0;
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            ordered_set.delete();
            sorted_due.delete();
            dropped_any = 1'b0;
        end else begin
            if (i_strobe === 1'b1) begin
                if (sorted_due.size() == 0) begin
                    fail_count++;
                    if (fail_count <= REPORT_LIMIT)
                        $display("[%0t] unexpected result word: value %0d last %0b ovf %0b",
                                 $realtime, i_result.sorted_value, i_result.last_out,
                                 i_result.overflowed);
                end else begin
                    want = sorted_due.pop_front();
                    results_checked++;
                    if (i_result.sorted_value !== want.sorted_value ||
                        i_result.last_out !== want.last_out ||
                        i_result.overflowed !== want.overflowed) begin
                        fail_count++;
                        if (fail_count <= REPORT_LIMIT)
                            $display({"[%0t] result mismatch: expected value %0d last %0b ",
                                      "ovf %0b, got value %0d last %0b ovf %0b"},
                                     $realtime, want.sorted_value, want.last_out,
                                     want.overflowed, i_result.sorted_value,
                                     i_result.last_out, i_result.overflowed);
                    end
                end
            end
            if (i_start === 1'b1 && i_busy === 1'b0)
                take_element(i_item);
        end
        o_fail_count    <= fail_count;
        o_pending       <= sorted_due.size();
        o_sets          <= sets_closed;
        o_overflow_sets <= overflow_sets;
        o_results       <= results_checked;
    end

endmodule

// File: dv/tb_top.sv
// Testbench top for the heap sort engine: clock, reset, word stimulus and verdict.
// Depends on hse_pkg, heap_sort_engine and hse_checker.
`timescale 1ns / 1ps

module tb_top;
    import hse_pkg::*;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int RANDOM_WORDS = 330;
    localparam int DRAIN_CYCLES = 300;

    localparam logic signed [DATA_WIDTH-1:0] BOUNDARY_SET [0:6] = '{
        32'sh7fff_ffff, 32'sh8000_0000, 32'sh0000_0000, 32'shffff_ffff,
        32'sh0000_0001, 32'sh8000_0000, 32'sh7fff_ffff
    };

    typedef enum logic [1:0] {
        VK_WIDE,
        VK_NARROW,
        VK_BOUNDARY
    } t_value_kind;

    logic        i_clk   = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start   = 1'b0;
    t_in_word    i_item  = '0;
    logic        busy;
    logic        o_strobe;
    t_out_word   o_result;

    int unsigned fail_count;
    int unsigned pending;
    int unsigned sets_closed;
    int unsigned overflow_sets;
    int unsigned results_checked;
    int unsigned cycle_count = 0;
    int unsigned words_sent  = 0;
    int unsigned burst_left  = 0;

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    heap_sort_engine i_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .i_item   (i_item),
        .busy     (busy),
        .o_strobe (o_strobe),
        .o_result (o_result)
    );

    hse_checker i_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_start         (start),
        .i_busy          (busy),
        .i_item          (i_item),
        .i_strobe        (o_strobe),
        .i_result        (o_result),
        .o_fail_count    (fail_count),
        .o_pending       (pending),
        .o_sets          (sets_closed),
        .o_overflow_sets (overflow_sets),
        .o_results       (results_checked)
    );

    function automatic logic signed [DATA_WIDTH-1:0] pick_value(input t_value_kind kind);
        case (kind)
            VK_NARROW: return $signed(32'($urandom_range(8))) - 32'sd4;
            VK_BOUNDARY: begin
                case ($urandom_range(4))
                    0:       return 32'sh8000_0000;
                    1:       return 32'sh7fff_ffff;
                    2:       return 32'sh0000_0000;
                    3:       return 32'shffff_ffff;
                    default: return 32'sh0000_0001;
                endcase
            end
            default: return $urandom;
        endcase
    endfunction

    task automatic pace();
        int unsigned gap;
        t_in_word    noise;
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = $urandom_range(12);
            gap = ($urandom_range(3) == 0) ? 0 :
                  $urandom_range(1, ($urandom_range(4) == 0) ? 40 : 6);
            if (gap > 0) begin
                noise.element = $urandom;
                noise.last_in = 1'($urandom);
                start  <= 1'b0;
                i_item <= noise;
                repeat (gap) @(posedge i_clk);
            end
        end
    endtask

    task automatic send_word(input logic signed [DATA_WIDTH-1:0] value, input logic closes);
        t_in_word w;
        w.element = value;
        w.last_in = closes;
        if (!start)
            start <= 1'b1;
        i_item <= w;
        @(posedge i_clk);
        while (busy)
            @(posedge i_clk);
        words_sent++;
        pace();
    endtask

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d result words outstanding",
                     cycle_count, pending);
            $display("status: fail");
            $finish;
        end
    end

    initial begin
        int unsigned set_len;
        int unsigned roll;
        t_value_kind kind;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_word(32'sh1234_5678, 1'b1);
        for (int k = 0; k < 7; k++)
            send_word(BOUNDARY_SET[k], k == 6);
        for (int k = 0; k < DEPTH_DEF; k++)
            send_word(32'sd100 - 32'sd13 * k, 1'b0);
        send_word(32'sh7fff_ffff, 1'b1);

        words_sent = 0;
        while (words_sent < RANDOM_WORDS) begin
            roll = $urandom_range(99);
            if (roll < 60)
                set_len = $urandom_range(1, 8);
            else if (roll < 88)
                set_len = $urandom_range(9, DEPTH_DEF);
            else
                set_len = $urandom_range(DEPTH_DEF + 1, DEPTH_DEF + 5);
            roll = $urandom_range(3);
            kind = (roll < 2) ? VK_WIDE : (roll == 2) ? VK_NARROW : VK_BOUNDARY;
            for (int k = 0; k < set_len; k++)
                send_word(pick_value(kind), k == set_len - 1);
        end

        if (start)
            start <= 1'b0;
        while (pending != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("covered %0d sets (%0d with dropped words), %0d result words checked",
                 sets_closed, overflow_sets, results_checked);
        $display("mismatches or stray words: %0d, result words never seen: %0d",
                 fail_count, pending);
        if (fail_count == 0 && pending == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

// File: sim.f
+incdir+hdl
hdl/hse_pkg.sv
hdl/hse_ctrl.sv
hdl/hse_datapath.sv
hdl/heap_sort_engine.sv
hdl/hse_checker.sv
dv/hse_checker.sv
dv/tb_top.sv
